// ----- src/generational_slot_allocator_macros.svh -----
// Assertion macros shared by the generational slot allocator RTL.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gsa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gsa assertion failed");

`endif

// ----- src/gsa_pkg.sv -----
// Shared constants, codes and control types of the generational slot allocator.
`default_nettype none

package gsa_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int PTR_W      = $clog2(SLOT_COUNT + 1);

    localparam int OP_W       = 2;
    localparam int HANDLE_W   = 10;
    localparam int GEN_W      = 32;
    localparam int OWNER_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;

    localparam logic [PTR_W-1:0] LIST_END = PTR_W'(SLOT_COUNT);
    localparam logic [GEN_W-1:0] GEN_MAX  = {GEN_W{1'b1}};
    localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CHECK   = 2'd2,
        OP_REBIND  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;   // accept the input transfer and start the slot read
        logic exec;      // finish the operation and load the result register
    } gsa_cmd_t;

    typedef struct packed {
        logic out_free;  // result register can take a new result this cycle
    } gsa_stat_t;

endpackage

`default_nettype wire

// ----- src/gsa_ctrl.sv -----
// Controller state machine of the generational slot allocator.
`default_nettype none

module gsa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gsa_pkg::gsa_stat_t  stat,
    output gsa_pkg::gsa_cmd_t   cmd
);
    import gsa_pkg::*;
    `include "generational_slot_allocator_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready     = (state_reg == S_IDLE);
    assign cmd.capture = s_valid && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `GSA_ASSERT_NEXT(a_capture_to_exec, aclk, aresetn, cmd.capture, state_reg == S_EXEC)
    `GSA_ASSERT_NEXT(a_exec_to_idle, aclk, aresetn, cmd.exec, state_reg == S_IDLE)

endmodule

`default_nettype wire

// ----- src/gsa_datapath.sv -----
// Datapath of the generational slot allocator: slot memories, free list and result register.
`default_nettype none

module gsa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gsa_pkg::gsa_cmd_t             cmd,
    output gsa_pkg::gsa_stat_t            stat,
    input  logic [gsa_pkg::OP_W-1:0]      s_op,
    input  logic [gsa_pkg::HANDLE_W-1:0]  s_slot_index,
    input  logic [gsa_pkg::GEN_W-1:0]     s_slot_generation,
    input  logic [gsa_pkg::OWNER_W-1:0]   s_owner_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gsa_pkg::STATUS_W-1:0]  m_status,
    output logic [gsa_pkg::HANDLE_W-1:0]  m_handle_index,
    output logic [gsa_pkg::GEN_W-1:0]     m_handle_generation,
    output logic [gsa_pkg::OWNER_W-1:0]   m_owner_out,
    output logic [gsa_pkg::COUNT_W-1:0]   m_live_count
);
    import gsa_pkg::*;
    `include "generational_slot_allocator_macros.svh"

    // Slot memories; data read from entries at or above the high-water mark is never used.
    logic [PTR_W-1:0]   next_free_mem  [SLOT_COUNT];
    logic [GEN_W-1:0]   generation_mem [SLOT_COUNT];
    logic               alive_mem      [SLOT_COUNT];
    logic [OWNER_W-1:0] owner_mem      [SLOT_COUNT];

    logic [PTR_W-1:0]   free_head_reg, free_head_next;
    logic [PTR_W-1:0]   high_water_reg, high_water_next;
    logic [PTR_W-1:0]   alive_total_reg, alive_total_next;

    // Captured transfer.
    op_t                op_reg;
    logic [HANDLE_W-1:0] idx_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [OWNER_W-1:0] owner_reg;

    // Registered read data.
    logic [PTR_W-1:0]   rd_next_free_reg;
    logic [GEN_W-1:0]   rd_gen_reg;
    logic               rd_alive_reg;
    logic [OWNER_W-1:0] rd_owner_reg;

    // Result register.
    logic                m_valid_reg;
    status_t             status_reg;
    logic [HANDLE_W-1:0] handle_index_reg;
    logic [GEN_W-1:0]    handle_gen_reg;
    logic [OWNER_W-1:0]  owner_out_reg;
    logic [COUNT_W-1:0]  live_count_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               from_list;
    logic               fresh;
    logic               live;
    logic [GEN_W-1:0]   bumped_gen;

    logic               wr_next_free_en;
    logic [PTR_W-1:0]   wr_next_free;
    logic               wr_gen_en;
    logic [GEN_W-1:0]   wr_gen;
    logic               wr_alive_en;
    logic               wr_alive;
    logic               wr_owner_en;
    logic [OWNER_W-1:0] wr_owner;

    status_t             res_status;
    logic [HANDLE_W-1:0] res_index;
    logic [GEN_W-1:0]    res_gen;
    logic [OWNER_W-1:0]  res_owner;

    assign stat.out_free = !m_valid_reg || m_ready;

    // Allocate reads the free-list head, every other operation its handle's slot.
    assign rd_addr = (op_t'(s_op) == OP_ALLOC) ? free_head_reg[IDX_W-1:0]
                                                : IDX_W'(s_slot_index);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg           <= op_t'(s_op);
            idx_reg          <= s_slot_index;
            gen_reg          <= s_slot_generation;
            owner_reg        <= s_owner_tag;
            rd_next_free_reg <= next_free_mem[rd_addr];
            rd_gen_reg       <= generation_mem[rd_addr];
            rd_alive_reg     <= alive_mem[rd_addr];
            rd_owner_reg     <= owner_mem[rd_addr];
        end
    end

    assign from_list  = (free_head_reg != LIST_END);
    assign fresh      = !from_list && (high_water_reg != LIST_END);
    assign live       = (gen_reg != '0)
                     && (32'(idx_reg) < 32'(high_water_reg))
                     && rd_alive_reg
                     && (rd_gen_reg == gen_reg);
    assign bumped_gen = (rd_gen_reg == GEN_MAX) ? GEN_FIRST : rd_gen_reg + GEN_FIRST;

    always_comb begin
        free_head_next   = free_head_reg;
        high_water_next  = high_water_reg;
        alive_total_next = alive_total_reg;
        wr_addr          = IDX_W'(idx_reg);
        wr_next_free_en  = 1'b0;
        wr_next_free     = LIST_END;
        wr_gen_en        = 1'b0;
        wr_gen           = GEN_FIRST;
        wr_alive_en      = 1'b0;
        wr_alive         = 1'b0;
        wr_owner_en      = 1'b0;
        wr_owner         = owner_reg;
        res_status       = STAT_OK;
        res_index        = idx_reg;
        res_gen          = gen_reg;
        res_owner        = '0;
        case (op_reg)
            OP_ALLOC: begin
                if (from_list) begin
                    wr_addr          = free_head_reg[IDX_W-1:0];
                    free_head_next   = rd_next_free_reg;
                    res_gen          = rd_gen_reg;
                end else if (fresh) begin
                    wr_addr          = high_water_reg[IDX_W-1:0];
                    high_water_next  = high_water_reg + PTR_W'(1);
                    wr_gen_en        = 1'b1;
                    wr_next_free_en  = 1'b1;
                    res_gen          = GEN_FIRST;
                end
                if (from_list || fresh) begin
                    wr_alive_en      = 1'b1;
                    wr_alive         = 1'b1;
                    wr_owner_en      = 1'b1;
                    alive_total_next = alive_total_reg + PTR_W'(1);
                    res_index        = HANDLE_W'(wr_addr);
                end else begin
                    res_status       = STAT_FULL;
                end
            end
            OP_RELEASE: begin
                if (!live) begin
                    res_status = STAT_INVALID;
                end else begin
                    wr_gen_en       = 1'b1;
                    wr_gen          = bumped_gen;
                    wr_owner_en     = 1'b1;
                    wr_owner        = '0;
                    wr_alive_en     = 1'b1;
                    wr_next_free_en = 1'b1;
                    wr_next_free    = free_head_reg;
                    free_head_next  = PTR_W'(idx_reg);
                    if (alive_total_reg != '0) begin
                        alive_total_next = alive_total_reg - PTR_W'(1);
                    end
                    res_gen         = bumped_gen;
                end
            end
            OP_CHECK: begin
                if (!live) begin
                    res_status = STAT_INVALID;
                end else begin
                    res_owner  = rd_owner_reg;
                end
            end
            default: begin
                if (!live) begin
                    res_status = STAT_INVALID;
                end else begin
                    wr_owner_en = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_next_free_en) begin
            next_free_mem[wr_addr] <= wr_next_free;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_gen_en) begin
            generation_mem[wr_addr] <= wr_gen;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_alive_en) begin
            alive_mem[wr_addr] <= wr_alive;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_owner_en) begin
            owner_mem[wr_addr] <= wr_owner;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg   <= LIST_END;
            high_water_reg  <= '0;
            alive_total_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.exec) begin
                free_head_reg   <= free_head_next;
                high_water_reg  <= high_water_next;
                alive_total_reg <= alive_total_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg       <= res_status;
            handle_index_reg <= res_index;
            handle_gen_reg   <= res_gen;
            owner_out_reg    <= res_owner;
            live_count_reg   <= COUNT_W'(alive_total_next);
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_handle_index      = handle_index_reg;
    assign m_handle_generation = handle_gen_reg;
    assign m_owner_out         = owner_out_reg;
    assign m_live_count        = live_count_reg;

    `GSA_ASSERT_SAME(a_live_below_hw, aclk, aresetn, 1'b1, alive_total_reg <= high_water_reg)
    `GSA_ASSERT_SAME(a_head_in_range, aclk, aresetn, 1'b1,
        (free_head_reg == LIST_END) || (free_head_reg < high_water_reg))
    `GSA_ASSERT_NEXT(a_exec_loads_out, aclk, aresetn, cmd.exec, m_valid_reg)

endmodule

`default_nettype wire

// ----- src/generational_slot_allocator.sv -----
// Top level of the generational slot allocator.
`default_nettype none

// Generational slot allocator: each input transfer carries one operation
// (allocate, release, check or rebind) and produces exactly one result
// transfer. A handle is a slot index plus a 32-bit generation; generation 0
// is never valid, and a release advances the generation, skipping 0 on wrap,
// so stale handles are rejected. Allocate reuses the most recently released
// slot first, then hands out never-used slots in order, and reports full when
// all slots are taken. An operation is captured (transfer taken, memories read
// at the addressed slot or the free-list head), then executed (decision made,
// memories written back, result register loaded). The single read and write
// port of the slot memories and the free-list head, which each allocate and
// release updates, keep a new transfer out until the last one is done. A
// finished result may wait in the output register while the next operation
// is being captured and read; it only has to be taken before that operation
// completes. No clearing pass is needed after reset: slots above the
// high-water mark are never used, so the first transfer is accepted at once.

module generational_slot_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gsa_pkg::OP_W-1:0]      s_op,
    input  logic [gsa_pkg::HANDLE_W-1:0]  s_slot_index,
    input  logic [gsa_pkg::GEN_W-1:0]     s_slot_generation,
    input  logic [gsa_pkg::OWNER_W-1:0]   s_owner_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gsa_pkg::STATUS_W-1:0]  m_status,
    output logic [gsa_pkg::HANDLE_W-1:0]  m_handle_index,
    output logic [gsa_pkg::GEN_W-1:0]     m_handle_generation,
    output logic [gsa_pkg::OWNER_W-1:0]   m_owner_out,
    output logic [gsa_pkg::COUNT_W-1:0]   m_live_count
);
    import gsa_pkg::*;

    // Command and status between the controller and the datapath.
    gsa_cmd_t  cmd;
    gsa_stat_t stat;

    // The controller sequences capture and completion of each operation.
    gsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the slot memories, free-list state and result register.
    gsa_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .s_op                (s_op),
        .s_slot_index        (s_slot_index),
        .s_slot_generation   (s_slot_generation),
        .s_owner_tag         (s_owner_tag),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_handle_index      (m_handle_index),
        .m_handle_generation (m_handle_generation),
        .m_owner_out         (m_owner_out),
        .m_live_count        (m_live_count)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_generational_slot_allocator.sv -----
// Self-checking testbench for the generational slot allocator.
`timescale 1ns / 100ps

// The testbench drives operations into the allocator through a valid/ready
// driver and checks every result transfer against its own prediction of the
// slot store. The prediction runs at the clock edge where an operation is
// accepted, so the expected replies line up in acceptance order with the
// results that the block returns, one result for each operation.
//
// A directed opening covers the handle corner cases: a fresh store, a zero
// generation, a mismatched generation, an index above the high-water mark, a
// slot that is no longer alive, and reuse of released slots from the free list.
// The random part then mixes well-formed allocate, release, check and rebind
// traffic on live handles with broken handles and pure noise. It also runs one
// long allocate burst that fills every slot and drives the store into full.
// A generation wrap needs about four billion releases of one slot, so it
// cannot be reached from the ports in a run of this length. The prediction
// still follows the wrap rule, so the check is ready for it.
module tb_generational_slot_allocator;

    import gsa_pkg::*;

    // One operation as it is offered on the input channel.
    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] index;
        logic [GEN_W-1:0]    gen;
        logic [OWNER_W-1:0]  owner;
    } slot_req_t;

    // One result as the block should return it.
    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] index;
        logic [GEN_W-1:0]    gen;
        logic [OWNER_W-1:0]  owner;
        logic [COUNT_W-1:0]  live;
    } slot_reply_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = '0;
    logic [HANDLE_W-1:0] s_slot_index = '0;
    logic [GEN_W-1:0]    s_slot_generation = '0;
    logic [OWNER_W-1:0]  s_owner_tag = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_handle_index;
    logic [GEN_W-1:0]    m_handle_generation;
    logic [OWNER_W-1:0]  m_owner_out;
    logic [COUNT_W-1:0]  m_live_count;

    generational_slot_allocator u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_op                (s_op),
        .s_slot_index        (s_slot_index),
        .s_slot_generation   (s_slot_generation),
        .s_owner_tag         (s_owner_tag),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_handle_index      (m_handle_index),
        .m_handle_generation (m_handle_generation),
        .m_owner_out         (m_owner_out),
        .m_live_count        (m_live_count)
    );

    // Shadow copy of the slot store. Entries at or above hwm are never read,
    // which matches the block, where those entries hold no defined value.
    int unsigned      link_mem  [SLOT_COUNT];
    logic [GEN_W-1:0] gen_mem   [SLOT_COUNT];
    bit               alive_mem [SLOT_COUNT];
    logic [OWNER_W-1:0] owner_mem [SLOT_COUNT];
    int unsigned      list_head = SLOT_COUNT;
    int               hwm = 0;
    int               live = 0;
    int               full_replies = 0;

    slot_req_t   req_q[$];     // operations waiting for the driver
    slot_reply_t reply_q[$];   // predicted results in acceptance order
    int          sent_cnt = 0;
    int          taken_cnt = 0;
    int          err_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          rx_hold = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic slot_req_t req(op_t op, logic [HANDLE_W-1:0] index,
                                      logic [GEN_W-1:0] gen, logic [OWNER_W-1:0] owner);
        slot_req_t rq;
        rq.op = op;
        rq.index = index;
        rq.gen = gen;
        rq.owner = owner;
        return rq;
    endfunction

    // Applies one accepted operation to the shadow store and returns the result
    // that the block must produce for it.
    function automatic slot_reply_t apply_slot_op(slot_req_t rq);
        slot_reply_t rs;
        int unsigned slot;
        logic [GEN_W-1:0] g;
        rs.status = STAT_OK;
        rs.index = rq.index;
        rs.gen = rq.gen;
        rs.owner = '0;
        slot = 32'(rq.index);
        if (rq.op == OP_ALLOC) begin
            // The free list comes first, then never-used slots, then full.
            if (list_head != SLOT_COUNT) begin
                slot = list_head;
                list_head = link_mem[slot];
            end else if (hwm < SLOT_COUNT) begin
                slot = hwm;
                hwm++;
                gen_mem[slot] = GEN_FIRST;
                link_mem[slot] = SLOT_COUNT;
            end else begin
                rs.status = STAT_FULL;
                full_replies++;
            end
            if (rs.status == STAT_OK) begin
                alive_mem[slot] = 1'b1;
                owner_mem[slot] = rq.owner;
                live++;
                rs.index = HANDLE_W'(slot);
                rs.gen = gen_mem[slot];
            end
        end else if (rq.gen == '0 || slot >= hwm || !alive_mem[slot] ||
                     gen_mem[slot] != rq.gen) begin
            // Such a handle leaves the store untouched and is echoed back.
            rs.status = STAT_INVALID;
        end else if (rq.op == OP_RELEASE) begin
            // The generation never goes back to zero when it wraps.
            g = (gen_mem[slot] == GEN_MAX) ? GEN_FIRST : gen_mem[slot] + GEN_FIRST;
            gen_mem[slot] = g;
            owner_mem[slot] = '0;
            alive_mem[slot] = 1'b0;
            link_mem[slot] = list_head;
            list_head = slot;
            if (live > 0)
                live--;
            rs.gen = g;
        end else if (rq.op == OP_CHECK) begin
            rs.owner = owner_mem[slot];
        end else begin
            owner_mem[slot] = rq.owner;
        end
        rs.live = COUNT_W'(live);
        return rs;
    endfunction

    // Finds some live slot, starting at a random point, or returns -1.
    function automatic int pick_live();
        int start;
        if (live == 0)
            return -1;
        start = $urandom_range(hwm - 1);
        for (int k = 0; k < hwm; k++) begin
            if (alive_mem[(start + k) % hwm])
                return (start + k) % hwm;
        end
        return -1;
    endfunction

    // Builds one random operation. Most of them are well-formed operations
    // on live handles. A band of broken handles follows, and the rest is
    // noise in every field.
    function automatic slot_req_t make_item(int alloc_pct, int rel_pct);
        int r;
        int slot;
        slot_req_t rq;
        r = $urandom_range(99);
        rq = req(OP_ALLOC, HANDLE_W'($urandom), $urandom, OWNER_W'($urandom));
        slot = pick_live();
        if (r < alloc_pct)
            return rq;
        if (r < alloc_pct + rel_pct) begin
            rq.op = OP_RELEASE;
        end else if (r < 88) begin
            rq.op = ($urandom_range(1) != 0) ? OP_CHECK : OP_REBIND;
        end else if (r < 96) begin
            rq.op = op_t'($urandom_range(OP_REBIND, OP_RELEASE));
            case ($urandom_range(3))
                0: rq.gen = '0;
                1: begin
                    if (slot >= 0) begin
                        rq.index = HANDLE_W'(slot);
                        rq.gen = gen_mem[slot] ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
                    end
                end
                2: begin
                    if (hwm < SLOT_COUNT) begin
                        rq.index = HANDLE_W'($urandom_range(SLOT_COUNT - 1, hwm));
                        rq.gen = GEN_FIRST;
                    end
                end
                default: begin
                    // A released slot with its current generation, or a live one.
                    if (hwm > 0) begin
                        rq.index = HANDLE_W'($urandom_range(hwm - 1));
                        rq.gen = gen_mem[rq.index];
                    end
                end
            endcase
            return rq;
        end else begin
            rq.op = op_t'($urandom_range(OP_REBIND, OP_ALLOC));
            return rq;
        end
        if (slot >= 0) begin
            rq.index = HANDLE_W'(slot);
            rq.gen = gen_mem[slot];
        end
        return rq;
    endfunction

    // Queues one operation at a rising edge. The queue is kept short, so the
    // random handles are picked from a nearly current view of the store.
    task automatic send(slot_req_t rq);
        @(posedge aclk);
        while (req_q.size() >= 4)
            @(posedge aclk);
        req_q = {req_q, rq};
    endtask

    // Waits until nothing is queued or offered and every result has come.
    // An item that is not offered at a rising edge has already had its result
    // predicted, so the result queue is safe to watch from then on.
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (req_q.size() != 0 || s_valid);
        while (reply_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        wait_drained();
        @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // Driver: a new item is offered only after the previous transfer has
    // been taken, so valid and payload hold steady while the block stalls.
    always @(negedge aclk) begin : drive
        slot_req_t rq;
        if (aresetn && taken_cnt == sent_cnt) begin
            if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                rq = req_q.pop_front();
                s_op <= rq.op;
                s_slot_index <= rq.index;
                s_slot_generation <= rq.gen;
                s_owner_tag <= rq.owner;
                s_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Each accepted input transfer is run through the prediction at once.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            reply_q = {reply_q, apply_slot_op(req(op_t'(s_op), s_slot_index,
                                                  s_slot_generation, s_owner_tag))};
            taken_cnt <= taken_cnt + 1;
        end
    end

    // Receiver back-pressure. A long hold, when one is requested, overrides
    // the random stalls.
    always @(negedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Monitor: every result transfer is checked against the oldest prediction.
    always @(posedge aclk) begin : monitor
        slot_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected result transfer: status %0d index %0d", m_status,
                       m_handle_index);
                err_count++;
            end else begin
                want = reply_q.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("handle_index", 32'(want.index), 32'(m_handle_index));
                check_field("handle_generation", want.gen, m_handle_generation);
                check_field("owner_out", 32'(want.owner), 32'(m_owner_out));
                check_field("live_count", 32'(want.live), 32'(m_live_count));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening on an empty store.
        send(req(OP_CHECK, 10'd0, 32'd1, 16'h0000));
        send(req(OP_RELEASE, 10'h3FF, GEN_MAX, 16'hFFFF));
        send(req(OP_ALLOC, 10'h3FF, GEN_MAX, 16'hFFFF));
        send(req(OP_ALLOC, 10'd0, 32'd0, 16'h0000));
        send(req(OP_CHECK, 10'd0, 32'd1, 16'h0000));
        send(req(OP_CHECK, 10'd0, 32'd0, 16'h0000));
        send(req(OP_CHECK, 10'd0, GEN_MAX, 16'h0000));
        send(req(OP_CHECK, 10'd2, 32'd1, 16'h0000));
        send(req(OP_REBIND, 10'd1, 32'd1, 16'hA5A5));
        send(req(OP_CHECK, 10'd1, 32'd1, 16'h0000));
        send(req(OP_REBIND, 10'd1, 32'd2, 16'h1234));
        send(req(OP_RELEASE, 10'd0, 32'd1, 16'h0000));
        // A repeated release uses a handle that has already gone stale.
        send(req(OP_RELEASE, 10'd0, 32'd1, 16'h0000));
        send(req(OP_CHECK, 10'd0, 32'd2, 16'h0000));
        send(req(OP_RELEASE, 10'd1, 32'd1, 16'h0000));
        // The next allocations reuse slot 1, then slot 0, then take a new slot.
        send(req(OP_ALLOC, 10'd0, 32'd0, 16'h5A5A));
        send(req(OP_ALLOC, 10'd0, 32'd0, 16'h0001));
        send(req(OP_ALLOC, 10'd0, 32'd0, 16'h8000));
        send(req(OP_REBIND, 10'd2, 32'd1, 16'hFFFF));
        send(req(OP_CHECK, 10'd2, 32'd1, 16'h0000));
        send(req(OP_RELEASE, 10'd2, 32'd1, 16'h0000));
        send(req(OP_CHECK, 10'd2, 32'd2, 16'h0000));

        // Random traffic with no idling on either side.
        set_idling(0, 0);
        repeat (200) begin
            @(negedge aclk);
            send(make_item(45, 15));
        end

        // The sender now leaves most cycles idle.
        set_idling(60, 0);
        repeat (200) begin
            @(negedge aclk);
            send(make_item(45, 15));
        end

        // Fill burst under receiver stalls. It opens with a long hold, during
        // which the sender keeps offering until the block stops accepting.
        // The burst ends after the store has reported full a few times.
        set_idling(0, 60);
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        forever begin
            @(negedge aclk);
            if (full_replies >= 3)
                break;
            send(make_item(90, 0));
        end

        // Churn near a full store. Releases feed the free list, and later
        // allocations take from it in last-in, first-out order.
        set_idling(16, 16);
        repeat (250) begin
            @(negedge aclk);
            send(make_item(30, 35));
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (err_count == 0 && reply_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // A correct run ends well before this limit, which leaves a wide margin.
    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/gsa_pkg.sv
src/gsa_ctrl.sv
src/gsa_datapath.sv
src/generational_slot_allocator.sv
tb/sv/tb_generational_slot_allocator.sv
